// File: rtl/core/strided_float_max_reduce_assert.svh
// Assertion macros shared by the max reduction RTL.
`ifndef STRIDED_FLOAT_MAX_REDUCE_ASSERT_SVH
`define STRIDED_FLOAT_MAX_REDUCE_ASSERT_SVH
// Assert that a condition implies a consequence in the same cycle.
`define SFMR_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define SFMR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/core/sfmr_pkg.sv
// Package with the widths, register indexes and compare function of the max reduction.
`default_nettype none
package sfmr_pkg;
	localparam int unsigned CHANNELS_MAX_DEF = 256;
	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned CC_W = 9;
	localparam int unsigned GC_W = 16;
	localparam int unsigned SC_W = 16;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned IDX_OUT_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 2'd2;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// Ordered greater-than on single-precision bit patterns; NaN compares false.
	function automatic logic ordered_gt(input sample_t a, input sample_t b);
		logic nan_a;
		logic nan_b;
		logic zeros;
		sample_t ka;
		sample_t kb;
		nan_a = a[30:0] > 31'h7F80_0000;
		nan_b = b[30:0] > 31'h7F80_0000;
		zeros = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
		ka = a[31] ? ~a : {1'b1, a[30:0]};
		kb = b[31] ? ~b : {1'b1, b[30:0]};
		ordered_gt = !nan_a && !nan_b && !zeros && (ka > kb);
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/strided_float_max_reduce.sv
// Strided maximum reduction over single-precision samples, top level.
`default_nettype none
// One sample per cycle, unless stage 2 stalls on a full result register. A
// sample is counted and its channel's running maximum read from a one-port-read
// synchronous memory in stage 1; stage 2 compares and writes the memory back,
// forwarding its result to a following read of the same channel, and loads the
// result register on the last group of a slice.
// A write to any of the three configuration registers restarts the job at channel 0, group 0, slice 0.
module strided_float_max_reduce #(
	parameter int unsigned CHANNELS_MAX = sfmr_pkg::CHANNELS_MAX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sfmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sfmr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [31:0]                   sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [31:0]                        channel_max,
	output logic [7:0]                         channel_index,
	output logic                               last_of_slice,
	output logic                               last_of_job
);
	localparam int unsigned AW = (CHANNELS_MAX > 1) ? $clog2(CHANNELS_MAX) : 1;
	localparam int unsigned PW = $clog2(CHANNELS_MAX + 1);
	localparam int unsigned IDX_OUT_W = sfmr_pkg::IDX_OUT_W;

	typedef struct packed {
		logic       first_gr;
		logic       emit;
		logic       last_ch;
		logic       last_job;
	} ctl_t;

	logic [sfmr_pkg::CC_W-1:0] cc_q;
	logic [sfmr_pkg::GC_W-1:0] gc_q;
	logic [sfmr_pkg::SC_W-1:0] sc_q;
	logic [AW-1:0] ch_q;
	logic [sfmr_pkg::GC_W-1:0] gr_q;
	logic [sfmr_pkg::SC_W-1:0] sl_q;

	sfmr_pkg::sample_t mem [CHANNELS_MAX];
	sfmr_pkg::sample_t rd_s2;
	sfmr_pkg::sample_t smp_s2;
	logic [AW-1:0] ch_s2;
	ctl_t ctl_s2;
	logic vld_s2;
	logic [AW-1:0] wch_s3;
	sfmr_pkg::sample_t wval_s3;
	logic wvld_s3;

	// Effective counts with zero read as one and oversize channel clamped.
	logic [PW-1:0] cc_eff;
	logic [sfmr_pkg::GC_W-1:0] gc_eff;
	logic [sfmr_pkg::SC_W-1:0] sc_eff;
	always_comb begin
		if (cc_q == '0) cc_eff = PW'(1);
		else if (32'(cc_q) > CHANNELS_MAX) cc_eff = PW'(CHANNELS_MAX);
		else cc_eff = PW'(cc_q);
		gc_eff = (gc_q == '0) ? sfmr_pkg::GC_W'(1) : gc_q;
		sc_eff = (sc_q == '0) ? sfmr_pkg::SC_W'(1) : sc_q;
	end

	logic accept;
	logic last_ch;
	logic last_gr;
	logic last_sl;
	logic out_free;
	assign out_free = !out_valid || out_ready;
	// Stage 2 stalls only when it must emit and the result register is full and not being taken.
	logic s2_stall;
	assign s2_stall = vld_s2 && ctl_s2.emit && !out_free;
	assign in_ready = !s2_stall;
	assign accept = in_valid && in_ready;
	assign last_ch = (PW'(ch_q) + PW'(1)) == cc_eff;
	assign last_gr = (gr_q + sfmr_pkg::GC_W'(1)) == gc_eff;
	assign last_sl = (sl_q + sfmr_pkg::SC_W'(1)) == sc_eff;

	// Configuration registers and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= sfmr_pkg::CC_W'(1);
			gc_q <= sfmr_pkg::GC_W'(1);
			sc_q <= sfmr_pkg::SC_W'(1);
			ch_q <= '0;
			gr_q <= '0;
			sl_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfmr_pkg::REG_CHANNEL_COUNT: cc_q <= cfg_data[sfmr_pkg::CC_W-1:0];
				sfmr_pkg::REG_GROUP_COUNT: gc_q <= cfg_data;
				sfmr_pkg::REG_SLICE_COUNT: sc_q <= cfg_data;
				default: ;
			endcase
			if (cfg_index == sfmr_pkg::REG_CHANNEL_COUNT
				|| cfg_index == sfmr_pkg::REG_GROUP_COUNT
				|| cfg_index == sfmr_pkg::REG_SLICE_COUNT) begin
				ch_q <= '0;
				gr_q <= '0;
				sl_q <= '0;
			end
		end else if (accept) begin
			if (last_ch) begin
				ch_q <= '0;
				if (last_gr) begin
					gr_q <= '0;
					sl_q <= last_sl ? '0 : sl_q + sfmr_pkg::SC_W'(1);
				end else begin
					gr_q <= gr_q + sfmr_pkg::GC_W'(1);
				end
			end else begin
				ch_q <= ch_q + AW'(1);
			end
		end
	end

	// Stage 1 to 2: memory read and control pipeline register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!s2_stall) begin
			vld_s2 <= accept;
		end
	end
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s2 <= mem[ch_q];
			smp_s2 <= sample;
			ch_s2 <= ch_q;
			ctl_s2.first_gr <= (gr_q == '0);
			ctl_s2.emit <= last_gr;
			ctl_s2.last_ch <= last_ch;
			ctl_s2.last_job <= last_ch && last_sl;
		end
	end

	// Stage 2: compare against the forwarded or read maximum, write back.
	sfmr_pkg::sample_t old_s2;
	sfmr_pkg::sample_t new_s2;
	logic fwd_s2;
	always_comb begin
		fwd_s2 = wvld_s3 && (wch_s3 == ch_s2);
		old_s2 = fwd_s2 ? wval_s3 : rd_s2;
		new_s2 = (ctl_s2.first_gr || !sfmr_pkg::ordered_gt(old_s2, smp_s2)) ? smp_s2 : old_s2;
	end
	logic wr_en;
	assign wr_en = vld_s2 && !s2_stall;
	always_ff @(posedge clk) begin
		if (wr_en) mem[ch_s2] <= new_s2;
	end
	// Last write kept for forwarding; a read in the same cycle as a write sees old data.
	// The entry is held while stage 2 stalls, since the stalled sample may still need it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_s3 <= 1'b0;
		end else if (!s2_stall) begin
			wvld_s3 <= wr_en;
		end
	end
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wch_s3 <= ch_s2;
			wval_s3 <= new_s2;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= wr_en && ctl_s2.emit;
		end
	end
	always_ff @(posedge clk) begin
		if (out_free && wr_en && ctl_s2.emit) begin
			channel_max <= new_s2;
			channel_index <= IDX_OUT_W'(ch_s2);
			last_of_slice <= ctl_s2.last_ch;
			last_of_job <= ctl_s2.last_job;
		end
	end

	`include "strided_float_max_reduce_assert.svh"
	`SFMR_ASSERT_IMPL(a_stall_full, clk, arst_n, s2_stall, out_valid && !out_ready, "stall without full result")
	`SFMR_ASSERT_NEXT(a_emit_valid, clk, arst_n, wr_en && ctl_s2.emit, out_valid, "emitted result not shown")
	`SFMR_ASSERT_IMPL(a_job_slice, clk, arst_n, out_valid && last_of_job, last_of_slice, "job end not slice end")
endmodule
`default_nettype wire

// File: tb/sv/tb_strided_float_max_reduce.sv
// Self-checking testbench for the strided single-precision max reduction.
`default_nettype none
module tb_strided_float_max_reduce;

	localparam int unsigned NUM_CH = 256;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam logic [sfmr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] channel_max;
		logic [7:0]  channel_index;
		logic        last_of_slice;
		logic        last_of_job;
	} max_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [sfmr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sfmr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [31:0]                     sample;
	logic                            out_valid;
	logic                            out_ready;
	logic [31:0]                     channel_max;
	logic [7:0]                      channel_index;
	logic                            last_of_slice;
	logic                            last_of_job;

	strided_float_max_reduce dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.channel_max(channel_max), .channel_index(channel_index),
		.last_of_slice(last_of_slice), .last_of_job(last_of_job)
	);

	// Mirror of the block state: per-channel maxima, positions and registers.
	logic [31:0] model_max [NUM_CH];
	int unsigned pos_ch, pos_gr, pos_sl;
	logic [8:0]  reg_cc;
	logic [15:0] reg_gc, reg_sc;
	max_result_t pending_max[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned sent;
	bit          quiet;

	always #1 clk = ~clk;

	// Timeout guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Ordered greater-than: NaNs and a pair of zeros never compare greater.
	function automatic bit float_greater(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ka, kb;
		if (a[30:23] == 8'hFF && a[22:0] != 0) return 0;
		if (b[30:23] == 8'hFF && b[22:0] != 0) return 0;
		if (a[30:0] == 0 && b[30:0] == 0) return 0;
		ka = a[31] ? ~a : {1'b1, a[30:0]};
		kb = b[31] ? ~b : {1'b1, b[30:0]};
		return ka > kb;
	endfunction

	// Advance the mirror by one accepted sample and queue the result it causes.
	task automatic predict_max(input logic [31:0] s);
		int unsigned cc, gc, sc, c;
		bit lc, lg, ls;
		max_result_t r;
		cc = (reg_cc == 0) ? 1 : (reg_cc > NUM_CH ? NUM_CH : reg_cc);
		gc = (reg_gc == 0) ? 1 : reg_gc;
		sc = (reg_sc == 0) ? 1 : reg_sc;
		c = pos_ch;
		if (pos_gr == 0 || !float_greater(model_max[c], s))
			model_max[c] = s;
		lc = (c + 1 == cc);
		lg = (pos_gr + 1 == gc);
		ls = (pos_sl + 1 == sc);
		if (lg) begin
			r.channel_max = model_max[c];
			r.channel_index = c[7:0];
			r.last_of_slice = lc;
			r.last_of_job = lc && ls;
			pending_max.push_back(r);
		end
		if (lc) begin
			pos_ch = 0;
			if (lg) begin
				pos_gr = 0;
				pos_sl = ls ? 0 : pos_sl + 1;
			end else begin
				pos_gr++;
			end
		end else begin
			pos_ch++;
		end
	endtask

	function automatic int unsigned draw_gap();
		return quiet ? 0 : $urandom_range(0, 3);
	endfunction

	// Send one sample; valid stays high afterwards so back-to-back transactions need no gap.
	task automatic send_sample(input logic [31:0] s);
		int unsigned g;
		g = draw_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!in_ready);
		predict_max(s);
		sent++;
	endtask

	// Write a register once the block has drained.
	task automatic set_register(input logic [sfmr_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] value);
		in_valid <= 1'b0;
		while (pending_max.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sfmr_pkg::REG_CHANNEL_COUNT: reg_cc = value[8:0];
			sfmr_pkg::REG_GROUP_COUNT: reg_gc = value;
			sfmr_pkg::REG_SLICE_COUNT: reg_sc = value;
			default: return;
		endcase
		pos_ch = 0;
		pos_gr = 0;
		pos_sl = 0;
	endtask

	task automatic set_shape(input logic [15:0] cc, input logic [15:0] gc, input logic [15:0] sc);
		set_register(sfmr_pkg::REG_CHANNEL_COUNT, cc);
		set_register(sfmr_pkg::REG_GROUP_COUNT, gc);
		set_register(sfmr_pkg::REG_SLICE_COUNT, sc);
	endtask

	// Mix of IEEE corner values and raw random patterns.
	function automatic logic [31:0] pick_sample();
		logic [31:0] corners [12];
		corners = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h7F7F_FFFF,
			32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h3F80_0000};
		if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 11)];
		return $urandom;
	endfunction

	// Result side: random stalls, then compare the accepted transaction.
	initial begin
		max_result_t want;
		int unsigned g;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			g = draw_gap();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_max.size() == 0) begin
				report("unexpected result", channel_max, 0);
			end else begin
				want = pending_max.pop_front();
				if (channel_max !== want.channel_max)
					report("channel_max", channel_max, want.channel_max);
				if (channel_index !== want.channel_index)
					report("channel_index", channel_index, want.channel_index);
				if (last_of_slice !== want.last_of_slice)
					report("last_of_slice", last_of_slice, want.last_of_slice);
				if (last_of_job !== want.last_of_job)
					report("last_of_job", last_of_job, want.last_of_job);
			end
		end
	end

	// Reset shape: every sample is its own job.
	task automatic test_reset_shape();
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h7F80_0000);
		send_sample(32'h8000_0000);
	endtask

	// NaN takeover, NaN drop, signed zeros and infinities on two channels.
	task automatic test_compare_cases();
		set_shape(16'd2, 16'd4, 16'd2);
		send_sample(32'h7FC0_0000); send_sample(32'h0000_0000);
		send_sample(32'h3F80_0000); send_sample(32'h8000_0000);
		send_sample(32'hFF80_0000); send_sample(32'h7F80_0001);
		send_sample(32'hBF80_0000); send_sample(32'hFF80_0000);
		send_sample(32'h8000_0000); send_sample(32'h7F80_0000);
		send_sample(32'h0000_0000); send_sample(32'h7F7F_FFFF);
		send_sample(32'h0000_0001); send_sample(32'hFFFF_FFFF);
		send_sample(32'h8000_0001); send_sample(32'hFF7F_FFFF);
	endtask

	// Register extremes: zero counts, oversized channel count, unused index,
	// largest group and slice counts, and a restart in the middle of a job.
	task automatic test_register_extremes();
		int unsigned i;
		set_shape(16'd0, 16'd0, 16'd0);
		send_sample(32'h4000_0000); send_sample(32'hC000_0000);
		set_shape(16'd511, 16'd1, 16'd1);
		for (i = 0; i < NUM_CH; i++) send_sample(pick_sample());
		set_shape(16'd256, 16'd2, 16'd1);
		for (i = 0; i < 2 * NUM_CH; i++) send_sample(pick_sample());
		set_shape(16'd1, 16'd1, 16'hFFFF);
		for (i = 0; i < 6; i++) send_sample(pick_sample());
		set_register(REG_UNUSED, 16'hFFFF);
		for (i = 0; i < 3; i++) send_sample(pick_sample());
		set_shape(16'd3, 16'hFFFF, 16'd2);
		for (i = 0; i < 7; i++) send_sample(pick_sample());
		set_shape(16'd3, 16'd3, 16'd2);
		for (i = 0; i < 4; i++) send_sample(pick_sample());
		set_register(sfmr_pkg::REG_GROUP_COUNT, 16'd2);
		for (i = 0; i < 12; i++) send_sample(pick_sample());
	endtask

	// Random shapes, mostly whole jobs, some cut short by the next write.
	task automatic test_random_jobs();
		int unsigned cc, gc, sc, n, i;
		while (sent < 1100) begin
			quiet = ($urandom_range(0, 4) == 0);
			cc = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			gc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
			sc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
			set_shape(16'(cc), 16'(gc), 16'(sc));
			n = cc * (gc == 0 ? 1 : gc) * (sc == 0 ? 1 : sc);
			if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
			else if ($urandom_range(0, 3) == 0) n = n * 2;
			for (i = 0; i < n; i++) send_sample(pick_sample());
		end
		quiet = 0;
	endtask

	initial begin
		clk = 1'b0;
		cycles = 0;
		errors = 0;
		sent = 0;
		quiet = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= sfmr_pkg::REG_CHANNEL_COUNT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample <= '0;
		reg_cc = 9'd1;
		reg_gc = 16'd1;
		reg_sc = 16'd1;
		pos_ch = 0;
		pos_gr = 0;
		pos_sl = 0;
		foreach (model_max[i]) model_max[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_shape();
		test_compare_cases();
		test_register_extremes();
		test_random_jobs();

		// Drain and settle.
		in_valid <= 1'b0;
		while (pending_max.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/sfmr_pkg.sv
rtl/core/strided_float_max_reduce.sv
tb/sv/tb_strided_float_max_reduce.sv
